FILE: hdl/sparse_polynomial_adder_core_macros.svh
// ----------------------------------------------------------------------------
// sparse polynomial adder assertion macros
// concurrent checks on the rising edge of clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef SPARSE_POLYNOMIAL_ADDER_CORE_MACROS_SVH
`define SPARSE_POLYNOMIAL_ADDER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// consequent must hold in the same cycle as the antecedent
`define SPA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spa check failed");

// consequent must hold in the cycle after the antecedent
`define SPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spa check failed");

`else

`define SPA_ASSERT_SAME(label, ante, cons)
`define SPA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: hdl/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// shared types and constants of the sparse polynomial adder
// ----------------------------------------------------------------------------
package spa_pkg;

  // term store capacity per polynomial
  localparam int MAX_TERMS = 16;
  localparam int ADDR_W    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);

  localparam int EXP_W     = 8;
  localparam int COEF_W    = 16;
  localparam int SUM_W     = COEF_W + 1;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 32;

  // operation codes carried in the input tuser
  typedef enum logic [1:0] {
    OP_LOAD_FIRST  = 2'd0,
    OP_LOAD_SECOND = 2'd1,
    OP_COMPUTE     = 2'd2,
    OP_NONE        = 2'd3
  } op_t;

  // one stored term
  typedef struct packed {
    logic [EXP_W-1:0]         exponent;
    logic signed [COEF_W-1:0] coefficient;
  } term_t;

  // control from the sequencer to a term store
  typedef struct packed {
    logic load;
    logic clear;
  } store_ctrl_t;

endpackage

FILE: hdl/spa_term_store.sv
// ----------------------------------------------------------------------------
// spa_term_store
// term memory of one polynomial with fill count and registered read port
// ----------------------------------------------------------------------------
module spa_term_store (
  input  logic                clk,
  input  logic                rst,
  input  spa_pkg::store_ctrl_t ctrl,
  input  spa_pkg::term_t      wr_term,
  input  logic [spa_pkg::CNT_W-1:0] rd_idx,
  output spa_pkg::term_t      rd_term,
  output logic [spa_pkg::CNT_W-1:0] count,
  output logic                full
);
  import spa_pkg::*;

  term_t mem [MAX_TERMS];

  assign full = (count == CNT_W'(MAX_TERMS));

  // fill count, cleared after a compute
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      count <= '0;
    end else if (ctrl.load && !full) begin
      count <= count + CNT_W'(1);
    end
  end

  // write at the fill position
  always_ff @(posedge clk) begin
    if (ctrl.load && !full) begin
      mem[count[ADDR_W-1:0]] <= wr_term;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_term <= mem[rd_idx[ADDR_W-1:0]];
  end

endmodule

FILE: hdl/sparse_polynomial_adder_core.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_adder_core: loads are taken while idle; a compute gives its sum
// terms one at a time after a start read, each by a memory read and a compare/add.
// Ready is low from a non-empty compute transfer until the last term transfers.
// rst (sync, active high) empties both stores and clears overflow.
// ----------------------------------------------------------------------------
`include "sparse_polynomial_adder_core_macros.svh"

module sparse_polynomial_adder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [spa_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // term_exponent, term_coefficient
  input  logic [1:0]  s_axis_tuser,                     // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [spa_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // sum_exponent, sum_coefficient
  output logic        m_axis_tlast,                     // last_term
  output logic [0:0]  m_axis_tuser                      // overflow_seen
);
  import spa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_MERGE = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0] idx_a, idx_b, idx_a_next, idx_b_next;
  logic [CNT_W-1:0] count_a, count_b;
  logic             full_a, full_b;
  term_t            term_a, term_b, in_term;
  store_ctrl_t      ctrl_a, ctrl_b;
  logic             overflow_flag;
  op_t              op;
  logic             in_xfer, out_xfer;

  // merge unit signals
  logic              valid_a, valid_b, use_a, use_b;
  logic [SUM_W-1:0]  add_a, add_b, sum;
  logic [EXP_W-1:0]  sum_exp;
  logic              last;

  // output register
  logic [EXP_W-1:0]  out_exp;
  logic [SUM_W-1:0]  out_coef;
  logic              out_last;
  logic              out_ovf;

  assign op      = op_t'(s_axis_tuser);
  assign in_term = '{exponent: s_axis_tdata[7:0], coefficient: s_axis_tdata[23:8]};
  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // store control
  assign ctrl_a = '{load: in_xfer && (op == OP_LOAD_FIRST),
                    clear: out_xfer && out_last};
  assign ctrl_b = '{load: in_xfer && (op == OP_LOAD_SECOND),
                    clear: out_xfer && out_last};

  spa_term_store u_store_a (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl_a),
    .wr_term (in_term),
    .rd_idx  (idx_a),
    .rd_term (term_a),
    .count   (count_a),
    .full    (full_a)
  );

  spa_term_store u_store_b (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl_b),
    .wr_term (in_term),
    .rd_idx  (idx_b),
    .rd_term (term_b),
    .count   (count_b),
    .full    (full_b)
  );

  // shared compare and add unit
  always_comb begin
    valid_a = (idx_a < count_a);
    valid_b = (idx_b < count_b);
    use_a   = valid_a && (!valid_b || (term_a.exponent >= term_b.exponent));
    use_b   = valid_b && (!valid_a || (term_b.exponent >= term_a.exponent));
    add_a   = use_a ? {term_a.coefficient[COEF_W-1], term_a.coefficient} : '0;
    add_b   = use_b ? {term_b.coefficient[COEF_W-1], term_b.coefficient} : '0;
    sum     = add_a + add_b;
    sum_exp = use_a ? term_a.exponent : term_b.exponent;
    idx_a_next = use_a ? idx_a + CNT_W'(1) : idx_a;
    idx_b_next = use_b ? idx_b + CNT_W'(1) : idx_b;
    last    = (idx_a_next >= count_a) && (idx_b_next >= count_b);
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer && (op == OP_COMPUTE) &&
            ((count_a != '0) || (count_b != '0))) begin
          state_next = S_READ;
        end
      end
      S_READ:  state_next = S_MERGE;
      S_MERGE: state_next = S_OUT;
      S_OUT: begin
        if (m_axis_tready) begin
          state_next = out_last ? S_IDLE : S_MERGE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // merge indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      idx_a <= '0;
      idx_b <= '0;
    end else if (state == S_IDLE) begin
      idx_a <= '0;
      idx_b <= '0;
    end else if (state == S_MERGE) begin
      idx_a <= idx_a_next;
      idx_b <= idx_b_next;
    end
  end

  // sticky overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_flag <= 1'b0;
    end else if ((ctrl_a.load && full_a) || (ctrl_b.load && full_b)) begin
      overflow_flag <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_MERGE) begin
      m_axis_tvalid <= 1'b1;
    end else if (out_xfer) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MERGE) begin
      out_exp  <= sum_exp;
      out_coef <= sum;
      out_last <= last;
      out_ovf  <= overflow_flag;
    end
  end

  assign m_axis_tdata = {{(OUT_DATA_W - SUM_W - EXP_W){1'b0}}, out_coef, out_exp};
  assign m_axis_tlast = out_last;
  assign m_axis_tuser = out_ovf;

  // checks
  `SPA_ASSERT_SAME(a_ready_out_empty, s_axis_tready, !m_axis_tvalid)
  `SPA_ASSERT_NEXT(a_last_clears, out_xfer && m_axis_tlast, count_a == '0 && count_b == '0)
  `SPA_ASSERT_NEXT(a_ovf_sticky, overflow_flag, overflow_flag)
  `SPA_ASSERT_SAME(a_count_bound, 1'b1, count_a <= CNT_W'(MAX_TERMS))

endmodule

FILE: tb/tb_sparse_polynomial_adder_core.sv
// ----------------------------------------------------------------------------
// tb_sparse_polynomial_adder_core
// Loads term lists into both stores over the input stream and asks for the
// sum. A built-in merge predictor works out every sum term, and each output
// transfer is checked against the oldest expected term. Both sides idle at
// random, the receiver holds off for a long stretch once, and a closing
// case fills both stores beyond capacity.
// ----------------------------------------------------------------------------
module tb_sparse_polynomial_adder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import spa_pkg::*;

  // slowest run: under 600 transfers in, each compute at most 32 terms, each
  // term slowed by heavy receiver idling, plus a long stall
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int LONG_STALL    = 400;
  localparam int DRAIN_CYCLES  = 20;
  localparam int BATCH_ITEMS   = 105;

  // one input item
  typedef struct {
    op_t              op;
    logic [7:0]       exponent;
    logic [15:0]      coefficient;
  } term_op_t;

  // one expected sum term
  typedef struct {
    logic [7:0]         exponent;
    logic signed [16:0] coefficient;
    logic               last;
    logic               overflow;
  } sum_term_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // term_exponent, term_coefficient
  logic [1:0]            s_axis_tuser = '0;   // operation
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // sum_exponent, sum_coefficient
  logic                  m_axis_tlast;        // last_term
  logic [0:0]            m_axis_tuser;        // overflow_seen

  term_op_t  pending_items[$];
  sum_term_t sum_terms_due[$];

  // predictor state
  term_t first_store[MAX_TERMS];
  term_t second_store[MAX_TERMS];
  int    first_len = 0;
  int    second_len = 0;
  logic  overflow_latched = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit long_stall_armed = 1'b0;
  bit long_stall_done = 1'b0;
  int stall_left = 0;
  int cycle_count = 0;
  int error_count = 0;

  sparse_polynomial_adder_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // update the store model for one accepted transfer, queue any sum terms
  task automatic apply_term_op(input op_t op, input logic [7:0] e, input logic [15:0] c);
    int        i;
    int        j;
    sum_term_t r;
    i = 0;
    j = 0;
    case (op)
      OP_LOAD_FIRST: begin
        if (first_len >= MAX_TERMS) overflow_latched = 1'b1;
        else begin
          first_store[first_len].exponent = e;
          first_store[first_len].coefficient = c;
          first_len++;
        end
      end
      OP_LOAD_SECOND: begin
        if (second_len >= MAX_TERMS) overflow_latched = 1'b1;
        else begin
          second_store[second_len].exponent = e;
          second_store[second_len].coefficient = c;
          second_len++;
        end
      end
      OP_COMPUTE: begin
        // merge by exponent, higher first, equal exponents summed
        while (i < first_len || j < second_len) begin
          if (i < first_len && j < second_len &&
              first_store[i].exponent == second_store[j].exponent) begin
            r.exponent = first_store[i].exponent;
            r.coefficient = $signed(first_store[i].coefficient) +
                            $signed(second_store[j].coefficient);
            i++;
            j++;
          end else if (j >= second_len ||
                       (i < first_len &&
                        first_store[i].exponent > second_store[j].exponent)) begin
            r.exponent = first_store[i].exponent;
            r.coefficient = $signed(first_store[i].coefficient);
            i++;
          end else begin
            r.exponent = second_store[j].exponent;
            r.coefficient = $signed(second_store[j].coefficient);
            j++;
          end
          r.last = (i >= first_len && j >= second_len);
          r.overflow = overflow_latched;
          sum_terms_due.push_back(r);
        end
        first_len = 0;
        second_len = 0;
      end
      default: ;
    endcase
  endtask

  // input driver: one item per transfer, random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        apply_term_op(op_t'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[23:8]);
      end
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= pending_items[0].op;
        s_axis_tdata <= {pending_items[0].coefficient, pending_items[0].exponent};
        void'(pending_items.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output ready: random idling, one long hold-off when armed
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (long_stall_armed && !long_stall_done) begin
      long_stall_done <= 1'b1;
      stall_left <= LONG_STALL;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic void check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // output monitor: compare each transfer with the oldest expected term
  always @(posedge clk) begin
    sum_term_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (sum_terms_due.size() == 0) begin
        $error("sum term with none expected: tdata %h last %b", m_axis_tdata, m_axis_tlast);
        error_count++;
      end else begin
        want = sum_terms_due.pop_front();
        check_field("sum_exponent", want.exponent, m_axis_tdata[7:0]);
        check_field("sum_coefficient", want.coefficient, $signed(m_axis_tdata[24:8]));
        check_field("tdata padding", 0, m_axis_tdata[31:25]);
        check_field("last_term", want.last, m_axis_tlast);
        check_field("overflow_seen", want.overflow, m_axis_tuser[0]);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_sparse_polynomial_adder_core failed");
      $finish;
    end
  end

  task automatic queue_item(input op_t op, input logic [7:0] e, input logic [15:0] c);
    term_op_t t;
    t.op = op;
    t.exponent = e;
    t.coefficient = c;
    pending_items.push_back(t);
  endtask

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 6);
    if (r < 95) return $urandom_range(7, MAX_TERMS - 1);
    return MAX_TERMS;
  endfunction

  // n terms, descending exponents from top with small gaps, or scrambled
  task automatic make_term_list(input int n, input bit ordered, input int top,
                                output term_t terms[$]);
    int    cur;
    int    room;
    int    e;
    term_t t;
    terms = {};
    cur = top;
    for (int k = 0; k < n; k++) begin
      if (ordered) begin
        room = cur - (n - 1 - k);
        e = cur - $urandom_range(0, (room < 3) ? room : 3);
        cur = e - 1;
      end else begin
        e = $urandom_range(0, 255);
      end
      t.exponent = e[7:0];
      t.coefficient = pick_coef();
      terms.push_back(t);
    end
  endtask

  // load/compute sequences until about target items are queued
  task automatic queue_random_terms(input int target);
    int    counted;
    bit    ordered;
    int    top;
    term_t first_list[$];
    term_t second_list[$];
    term_t t;
    counted = 0;
    while (counted < target) begin
      ordered = ($urandom_range(0, 9) != 0);
      top = $urandom_range(31, 255);
      make_term_list(pick_count(), ordered, top, first_list);
      make_term_list(pick_count(), ordered, top, second_list);
      // interleave the two loads in random order, with some noise
      while (first_list.size() > 0 || second_list.size() > 0) begin
        if ($urandom_range(0, 19) == 0) queue_item(OP_NONE, 8'($urandom), 16'($urandom));
        if (second_list.size() == 0 || (first_list.size() > 0 && $urandom_range(0, 1))) begin
          t = first_list.pop_front();
          queue_item(OP_LOAD_FIRST, t.exponent, t.coefficient);
        end else begin
          t = second_list.pop_front();
          queue_item(OP_LOAD_SECOND, t.exponent, t.coefficient);
        end
        counted++;
      end
      queue_item(OP_COMPUTE, 8'($urandom), 16'($urandom));
      counted++;
    end
  endtask

  // wait until every item has been sent and every sum term has arrived
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() > 0 || s_axis_tvalid || sum_terms_due.size() > 0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // sender idles rarely, receiver mostly
    send_idle_pct = 11;
    recv_idle_pct = 88;
    // compute on empty stores, unused code
    queue_item(OP_COMPUTE, 8'h5a, 16'ha5a5);
    queue_item(OP_NONE, 8'hff, 16'hffff);
    // extreme exponents and coefficients, equal exponents, zero sum
    queue_item(OP_LOAD_FIRST, 8'd255, 16'h8000);
    queue_item(OP_LOAD_SECOND, 8'd255, 16'h8000);
    queue_item(OP_LOAD_FIRST, 8'd128, 16'h7fff);
    queue_item(OP_LOAD_SECOND, 8'd128, 16'h7fff);
    queue_item(OP_LOAD_FIRST, 8'd7, 16'd100);
    queue_item(OP_LOAD_SECOND, 8'd7, -16'sd100);
    queue_item(OP_LOAD_FIRST, 8'd0, 16'hffff);
    queue_item(OP_COMPUTE, 8'd0, 16'd0);
    // only the second store loaded
    queue_item(OP_LOAD_SECOND, 8'd10, 16'd5);
    queue_item(OP_LOAD_SECOND, 8'd0, 16'h8000);
    queue_item(OP_COMPUTE, 8'hff, 16'hffff);
    // single term in the first store
    queue_item(OP_LOAD_FIRST, 8'haa, 16'h5555);
    queue_item(OP_COMPUTE, 8'h55, 16'haaaa);
    // unordered loads
    queue_item(OP_LOAD_FIRST, 8'd3, 16'd1);
    queue_item(OP_LOAD_FIRST, 8'd200, 16'd2);
    queue_item(OP_LOAD_SECOND, 8'd100, 16'd3);
    queue_item(OP_LOAD_SECOND, 8'd3, 16'd4);
    queue_item(OP_COMPUTE, 8'd0, 16'd0);
    queue_random_terms(BATCH_ITEMS);
    wait_drained();

    // receiver idles rarely, sender mostly
    send_idle_pct = 88;
    recv_idle_pct = 11;
    queue_random_terms(BATCH_ITEMS);
    wait_drained();

    // no idling, one long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_stall_armed = 1'b1;
    queue_random_terms(BATCH_ITEMS);
    // both stores beyond capacity, then the sticky flag on a later compute
    for (int k = MAX_TERMS; k >= 0; k--) queue_item(OP_LOAD_FIRST, 8'(k * 15), pick_coef());
    for (int k = MAX_TERMS; k >= 0; k--) queue_item(OP_LOAD_SECOND, 8'(k * 14), pick_coef());
    queue_item(OP_COMPUTE, 8'd0, 16'd0);
    queue_item(OP_LOAD_SECOND, 8'd42, 16'd42);
    queue_item(OP_COMPUTE, 8'd0, 16'd0);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_sparse_polynomial_adder_core passed");
    end else begin
      $display("tb_sparse_polynomial_adder_core failed");
    end
    $finish;
  end

endmodule
